FILE: design/rqf_pkg.sv
// Shared types, constants and register codes for the read quality filter.
// No dependencies; every other design file imports this package.
package rqf_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int THR_W       = 9;
  localparam int PROD_W      = THR_W + LENGTH_BITS;

  localparam int MID_DEPTH   = 2;
  localparam int MID_PTR_W   = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
  localparam int MID_CNT_W   = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  localparam logic [7:0] BASE_N = 8'h4E;

  typedef logic [LENGTH_BITS-1:0] count_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLES     = 3'd0,
    REG_LQ_LIMIT    = 3'd1,
    REG_LQ_BASES    = 3'd2,
    REG_N_BASES     = 3'd3,
    REG_MIN_LEN     = 3'd4,
    REG_MAX_LEN     = 3'd5,
    REG_CPLX_THRESH = 3'd6
  } rqf_reg_e;

  typedef enum logic [2:0] {
    VERDICT_PASS     = 3'd0,
    VERDICT_SHORT    = 3'd1,
    VERDICT_LOW_QUAL = 3'd2,
    VERDICT_MANY_N   = 3'd3,
    VERDICT_LONG     = 3'd4,
    VERDICT_LOW_CPLX = 3'd5
  } verdict_t;

  // Filter settings as seen by both halves of the block.
  typedef struct packed {
    logic [2:0]       enables;
    logic [7:0]       lq_limit;
    count_t           lq_bases;
    count_t           n_bases;
    count_t           min_len;
    count_t           max_len;
    logic [THR_W-1:0] cplx_thresh;
  } rqf_cfg_t;

  // Final counts of one read, handed from the front to the judge.
  typedef struct packed {
    count_t len;
    count_t n_cnt;
    count_t lq_cnt;
    count_t chg_cnt;
  } rqf_rec_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : count_t'(v + 1'b1);
  endfunction

endpackage

FILE: design/rqf_front.sv
// Front half: per-base counter update and read record hand-off.
// Depends on rqf_pkg.
module rqf_front
  import rqf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rqf_cfg_t   cfg,
  input  logic       take,
  input  logic [7:0] base,
  input  logic [7:0] quality,
  input  logic       last,
  output logic       rec_push,
  output rqf_rec_t   rec
);

  count_t     len_r, len_nxt;
  count_t     n_r, n_nxt;
  count_t     lq_r, lq_nxt;
  count_t     chg_r, chg_nxt;
  logic [7:0] prev_r;

  always_comb begin
    len_nxt = sat_inc(len_r);
    n_nxt   = (base == BASE_N) ? sat_inc(n_r) : n_r;
    lq_nxt  = (quality < cfg.lq_limit) ? sat_inc(lq_r) : lq_r;
    // no change is counted on the first base of a read
    chg_nxt = (len_r != '0 && base != prev_r) ? sat_inc(chg_r) : chg_r;
  end

  assign rec_push    = take && last;
  assign rec.len     = len_nxt;
  assign rec.n_cnt   = n_nxt;
  assign rec.lq_cnt  = lq_nxt;
  assign rec.chg_cnt = chg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      n_r   <= '0;
      lq_r  <= '0;
      chg_r <= '0;
    end else if (take) begin
      if (last) begin
        len_r <= '0;
        n_r   <= '0;
        lq_r  <= '0;
        chg_r <= '0;
      end else begin
        len_r <= len_nxt;
        n_r   <= n_nxt;
        lq_r  <= lq_nxt;
        chg_r <= chg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prev_r <= base;
    end
  end

endmodule

FILE: design/rqf_queue.sv
// Short record queue between the front and the judge.
// Depends on rqf_pkg.
module rqf_queue
  import rqf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rqf_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output rqf_rec_t head
);

  rqf_rec_t             mem_r [MID_DEPTH];
  logic [MID_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [MID_CNT_W-1:0] cnt_r;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == MID_CNT_W'(MID_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == MID_PTR_W'(MID_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

FILE: design/rqf_judge.sv
// Back half: two-step verdict for each read record and the result queue.
// Depends on rqf_pkg.
module rqf_judge
  import rqf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rqf_cfg_t   cfg,
  input  logic       rec_valid,
  input  rqf_rec_t   rec,
  output logic       rec_pop,
  input  logic       res_pop,
  output logic       res_empty,
  output logic [2:0] res_verdict
);

  // stage one: compares and the threshold product
  logic                    s1_v_r;
  logic [2:0]              s1_en_r;
  logic                    s1_lq_fail_r, s1_n_fail_r, s1_short_r, s1_long_r, s1_le1_r;
  logic [LENGTH_BITS+7:0]  s1_chg_r;
  logic [PROD_W-1:0]       s1_need_r;
  count_t                  len_m1;

  // result queue
  verdict_t             mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;
  logic                 res_push, do_pop;
  verdict_t             verdict;
  logic                 cplx_fail;

  // launch only with a free slot reserved for the record in flight
  assign rec_pop = rec_valid &&
                   ((OUT_CNT_W+1)'(cnt_r) + (OUT_CNT_W+1)'(s1_v_r) <
                    (OUT_CNT_W+1)'(OUT_DEPTH));
  assign len_m1  = count_t'(rec.len - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= rec_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      s1_en_r      <= cfg.enables;
      s1_lq_fail_r <= rec.lq_cnt > cfg.lq_bases;
      s1_n_fail_r  <= rec.n_cnt > cfg.n_bases;
      s1_short_r   <= rec.len < cfg.min_len;
      s1_long_r    <= (cfg.max_len != '0) && (rec.len > cfg.max_len);
      s1_le1_r     <= rec.len <= count_t'(1);
      s1_chg_r     <= {rec.chg_cnt, 8'h00};
      s1_need_r    <= PROD_W'(cfg.cplx_thresh) * PROD_W'(len_m1);
    end
  end

  always_comb begin
    cplx_fail = s1_le1_r || (PROD_W'(s1_chg_r) < s1_need_r);
    verdict   = VERDICT_PASS;
    if (s1_en_r[0] && s1_lq_fail_r) begin
      verdict = VERDICT_LOW_QUAL;
    end else if (s1_en_r[0] && s1_n_fail_r) begin
      verdict = VERDICT_MANY_N;
    end else if (s1_en_r[1] && s1_short_r) begin
      verdict = VERDICT_SHORT;
    end else if (s1_en_r[1] && s1_long_r) begin
      verdict = VERDICT_LONG;
    end else if (s1_en_r[2] && cplx_fail) begin
      verdict = VERDICT_LOW_CPLX;
    end
  end

  assign res_push    = s1_v_r;
  assign res_empty   = (cnt_r == '0);
  assign res_verdict = mem_r[rd_ptr_r];
  assign do_pop      = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (res_push) begin
        wr_ptr_r <= (wr_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({res_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      mem_r[wr_ptr_r] <= verdict;
    end
  end

endmodule

FILE: design/read_quality_filter.sv
// Read quality filter top level: settings registers, front, record queue, judge.
// Depends on rqf_pkg, rqf_front, rqf_queue and rqf_judge.
//
// Bases of a read stream in one per cycle (one beat per base) with their ASCII
// quality and a last flag; the block takes a beat in every cycle while in_full
// is low. The front updates saturating counts of length, N bases, low-quality
// bases and base changes for each beat taken; on the last base it hands the
// read's counts to a two-entry record queue. The judge takes one record per
// cycle while the result queue has room for it, registers the limit compares
// and the threshold-times-(length-1) product, then picks the verdict and
// writes it to a four-entry result queue; a verdict passes the record queue
// and the judge's stage-one registers before it is ready. in_full rises only
// when the record queue is full, which happens when the result queue is not
// being popped. Settings are written through the cfg_ port (always ready) and
// must only change while no read is in progress or in flight.
module read_quality_filter
  import rqf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // base beats
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [7:0]            in_base,
  input  logic [7:0]            in_quality,
  input  logic                  in_last,
  // verdict beats
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [2:0]            out_verdict,
  // settings writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  rqf_cfg_t cfg_r;
  logic     take;
  logic     rec_push;
  rqf_rec_t rec_in;
  logic     mid_empty;
  logic     mid_pop;
  rqf_rec_t mid_head;

  assign cfg_ready = 1'b1;

  // Settings registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enables     <= 3'd0;
      cfg_r.lq_limit    <= 8'd48;
      cfg_r.lq_bases    <= count_t'(40);
      cfg_r.n_bases     <= count_t'(5);
      cfg_r.min_len     <= count_t'(15);
      cfg_r.max_len     <= '0;
      cfg_r.cplx_thresh <= THR_W'(77);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLES:     cfg_r.enables     <= cfg_data[2:0];
        REG_LQ_LIMIT:    cfg_r.lq_limit    <= cfg_data[7:0];
        REG_LQ_BASES:    cfg_r.lq_bases    <= count_t'(cfg_data);
        REG_N_BASES:     cfg_r.n_bases     <= count_t'(cfg_data);
        REG_MIN_LEN:     cfg_r.min_len     <= count_t'(cfg_data);
        REG_MAX_LEN:     cfg_r.max_len     <= count_t'(cfg_data);
        REG_CPLX_THRESH: cfg_r.cplx_thresh <= cfg_data[THR_W-1:0];
        default:         cfg_r             <= cfg_r;
      endcase
    end
  end

  // Hold off new bases only while the record queue has no room.
  assign take = in_push && !in_full;

  rqf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .take     (take),
    .base     (in_base),
    .quality  (in_quality),
    .last     (in_last),
    .rec_push (rec_push),
    .rec      (rec_in)
  );

  rqf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec_in),
    .full     (in_full),
    .pop      (mid_pop),
    .empty    (mid_empty),
    .head     (mid_head)
  );

  rqf_judge u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .rec_valid   (!mid_empty),
    .rec         (mid_head),
    .rec_pop     (mid_pop),
    .res_pop     (out_pop),
    .res_empty   (out_empty),
    .res_verdict (out_verdict)
  );

endmodule

FILE: design/rqf_checker.sv
// Port-level checks for the read quality filter, bound to the top level.
// Depends on rqf_pkg and read_quality_filter.
module rqf_checker
  import rqf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [2:0] out_verdict,
  input logic       cfg_ready
);

  // Reset leaves both queues empty.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting verdict holds until popped.
  a_verdict_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_verdict))
    else $error("waiting verdict changed or vanished");

  // Only defined verdict codes leave the block.
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_verdict <= VERDICT_LOW_CPLX)
    else $error("undefined verdict code");

  // Settings writes are never refused.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("settings port not ready");

endmodule

bind read_quality_filter rqf_checker u_rqf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_full     (in_full),
  .out_empty   (out_empty),
  .out_pop     (out_pop),
  .out_verdict (out_verdict),
  .cfg_ready   (cfg_ready)
);

FILE: sim/read_quality_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for read_quality_filter: directed, random and fill tests.
// Depends on rqf_pkg and the read_quality_filter RTL; predicts each verdict from its own model.
module read_quality_filter_tb;
  import rqf_pkg::*;

  // Spare register index: writes to it must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  // Cycles to let pass once the last verdict is in, before a write or the end.
  localparam int SETTLE_CYCLES = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic [7:0]            in_base;
  logic [7:0]            in_quality;
  logic                  in_last;
  logic                  out_empty;
  logic                  out_pop;
  logic [2:0]            out_verdict;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  read_quality_filter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_base    (in_base),
    .in_quality (in_quality),
    .in_last    (in_last),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_verdict(out_verdict),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the filter: settings, running counts of the read in progress and
  // the verdicts still owed by the block, oldest first.
  // ---------------------------------------------------------------------------
  rqf_cfg_t   shadow;
  count_t     cur_len;
  count_t     cur_n;
  count_t     cur_lq;
  count_t     cur_chg;
  logic [7:0] cur_prev;
  verdict_t   pending_verdicts[$];

  // Knobs shared by the stimulus and the receiver.
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int hold_len      = 0;
  int hold_seq      = 0;

  // Run statistics.
  int mismatches       = 0;
  int beats_sent       = 0;
  int reads_sent       = 0;
  int verdicts_checked = 0;
  int full_cycles      = 0;

  function automatic count_t bump(input count_t v);
    // Saturate at all ones.
    return (&v) ? v : count_t'(v + 1);
  endfunction

  function automatic void clear_read();
    cur_len  = '0;
    cur_n    = '0;
    cur_lq   = '0;
    cur_chg  = '0;
    cur_prev = 8'h00;
  endfunction

  function automatic void reset_shadow();
    shadow.enables     = 3'd0;
    shadow.lq_limit    = 8'd48;
    shadow.lq_bases    = count_t'(40);
    shadow.n_bases     = count_t'(5);
    shadow.min_len     = count_t'(15);
    shadow.max_len     = '0;
    shadow.cplx_thresh = 9'd77;
    clear_read();
  endfunction

  // Verdict for the read just closed; the first failing check wins.
  function automatic verdict_t judge_read();
    logic [63:0] changes_scaled;
    logic [63:0] needed;
    if (shadow.enables[0]) begin
      if (cur_lq > shadow.lq_bases) return VERDICT_LOW_QUAL;
      if (cur_n > shadow.n_bases) return VERDICT_MANY_N;
    end
    if (shadow.enables[1]) begin
      if (cur_len < shadow.min_len) return VERDICT_SHORT;
      if (shadow.max_len != 0 && cur_len > shadow.max_len) return VERDICT_LONG;
    end
    if (shadow.enables[2]) begin
      if (cur_len <= 1) return VERDICT_LOW_CPLX;
      changes_scaled = 64'(cur_chg) * 64'd256;
      needed         = 64'(shadow.cplx_thresh) * 64'(cur_len - 1'b1);
      if (changes_scaled < needed) return VERDICT_LOW_CPLX;
    end
    return VERDICT_PASS;
  endfunction

  // Advance the shadow by one accepted base; queue a verdict on the last one.
  function automatic void predict_base(input logic [7:0] b, input logic [7:0] q,
                                       input logic l);
    if (b == BASE_N) cur_n = bump(cur_n);
    if (q < shadow.lq_limit) cur_lq = bump(cur_lq);
    // The first base of a read has nothing to differ from.
    if (cur_len != 0 && b != cur_prev) cur_chg = bump(cur_chg);
    cur_prev = b;
    cur_len  = bump(cur_len);
    beats_sent++;
    if (l) begin
      pending_verdicts.push_back(judge_read());
      reads_sent++;
      clear_read();
    end
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_ENABLES:     shadow.enables     = val[2:0];
      REG_LQ_LIMIT:    shadow.lq_limit    = val[7:0];
      REG_LQ_BASES:    shadow.lq_bases    = count_t'(val);
      REG_N_BASES:     shadow.n_bases     = count_t'(val);
      REG_MIN_LEN:     shadow.min_len     = count_t'(val);
      REG_MAX_LEN:     shadow.max_len     = count_t'(val);
      REG_CPLX_THRESH: shadow.cplx_thresh = val[THR_W-1:0];
      default: ;  // unused index: drop the write
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pops at random, or holds off for a requested number of cycles.
  // A new hold is requested by bumping hold_seq after setting hold_len.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_pop   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (!rst_n || hold_left > 0) begin
        out_pop <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        out_pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // Check every verdict beat against the oldest prediction.
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (rst_n) begin
      if (in_push && in_full) full_cycles++;
      if (out_pop && !out_empty) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict %0d with none outstanding", out_verdict));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_verdict !== want)
            report_mismatch($sformatf("verdict %0d, predicted %0d (%s)",
                                      out_verdict, want, want.name()));
        end
        verdicts_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one base beat and hold it until the block takes it. in_push is left
  // high so that back-to-back beats need no lowering in between.
  task automatic send_beat(input logic [7:0] b, input logic [7:0] q, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_base    <= b;
    in_quality <= q;
    in_last    <= l;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_base(b, q, l);
  endtask

  // Lower push and wait until every verdict has come back, then settle.
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly nucleotides, repeats to pull complexity down, now and then N or a stray byte.
  function automatic logic [7:0] pick_base(input logic [7:0] prev);
    int r;
    r = $urandom_range(99);
    if (r < 30) return prev;
    if (r < 36) return BASE_N;
    if (r < 97) begin
      case ($urandom_range(3))
        0:       return 8'h41;
        1:       return 8'h43;
        2:       return 8'h47;
        default: return 8'h54;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_quality();
    if ($urandom_range(99) < 90) return 8'(33 + $urandom_range(41));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_read(input int len, input bit noisy);
    logic [7:0] b;
    logic [7:0] q;
    logic [7:0] prev;
    prev = 8'h41;
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        b = 8'($urandom_range(255));
        q = 8'($urandom_range(255));
      end else begin
        b = pick_base(prev);
        q = pick_quality();
      end
      send_beat(b, q, i == len - 1);
      prev = b;
    end
  endtask

  // Random read: mostly short, some longer, a tenth pure noise.
  task automatic send_random_read();
    int len;
    len = ($urandom_range(99) < 85) ? $urandom_range(20, 1) : $urandom_range(64, 21);
    send_read(len, $urandom_range(9) == 0);
  endtask

  // Fresh settings with the extremes coming up often. Call only while idle.
  task automatic pick_settings();
    logic [CFG_DATA_W-1:0] v;
    v = ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'd7;
    write_setting(REG_ENABLES, v);
    case ($urandom_range(3))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'(33 + $urandom_range(45));
    endcase
    write_setting(REG_LQ_LIMIT, v);
    case ($urandom_range(3))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(8));
    endcase
    write_setting(REG_LQ_BASES, v);
    case ($urandom_range(3))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(3));
    endcase
    write_setting(REG_N_BASES, v);
    case ($urandom_range(7))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(20, 1));
    endcase
    write_setting(REG_MIN_LEN, v);
    case ($urandom_range(5))
      0:       v = 16'd0;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom_range(40, 1));
    endcase
    write_setting(REG_MAX_LEN, v);
    case ($urandom_range(5))
      0:       v = 16'd0;
      1:       v = 16'd256;
      2:       v = 16'hFFFF;  // truncates to the top threshold, which always fails
      default: v = 16'($urandom_range(200));
    endcase
    write_setting(REG_CPLX_THRESH, v);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: everything off, then the default limits once enabled.
  task automatic test_defaults();
    send_beat(8'h41, 8'h49, 1'b1);          // all checks off: pass
    wait_idle();
    write_setting(REG_ENABLES, 16'hFFFF);   // upper data bits are dropped
    send_beat(8'h41, 8'h49, 1'b1);          // shorter than the default minimum
    send_beat(BASE_N, 8'h00, 1'b1);
    wait_idle();
    // An unused index must not land on any register.
    write_setting(REG_SPARE, 16'h0000);
    send_beat(8'h43, 8'h49, 1'b1);
  endtask

  // Each check on its own, the order between checks, and the threshold extremes.
  task automatic test_checks_directed();
    wait_idle();
    write_setting(REG_LQ_BASES, 16'd0);
    write_setting(REG_N_BASES, 16'd0);
    write_setting(REG_MIN_LEN, 16'd0);
    write_setting(REG_MAX_LEN, 16'd2);
    write_setting(REG_CPLX_THRESH, 16'd256);
    write_setting(REG_LQ_LIMIT, 16'd255);
    write_setting(REG_ENABLES, 16'd1);
    send_beat(8'h00, 8'hFE, 1'b1);          // low quality
    wait_idle();
    write_setting(REG_LQ_LIMIT, 16'd0);
    send_beat(BASE_N, 8'hFF, 1'b1);         // too many N
    wait_idle();
    write_setting(REG_LQ_LIMIT, 16'd1);
    send_beat(BASE_N, 8'h00, 1'b1);         // both fail: low quality wins
    wait_idle();
    write_setting(REG_ENABLES, 16'd2);
    send_beat(8'hFF, 8'h49, 1'b0);
    send_beat(8'hFF, 8'h49, 1'b0);
    send_beat(8'hFF, 8'h49, 1'b1);          // longer than the maximum
    send_beat(8'h41, 8'h49, 1'b1);          // within bounds
    wait_idle();
    write_setting(REG_ENABLES, 16'd4);
    send_beat(8'h41, 8'h49, 1'b0);
    send_beat(8'h43, 8'h49, 1'b1);          // one change in one gap: just passes
    send_beat(8'h41, 8'h49, 1'b0);
    send_beat(8'h41, 8'h49, 1'b1);          // no change
    wait_idle();
    write_setting(REG_CPLX_THRESH, 16'hFFFF);
    send_beat(8'h41, 8'h49, 1'b0);
    send_beat(8'h43, 8'h49, 1'b1);          // threshold above full scale always fails
    send_beat(8'h47, 8'h49, 1'b1);          // single base always fails complexity
    wait_idle();
    write_setting(REG_ENABLES, 16'd6);
    write_setting(REG_MAX_LEN, 16'd0);      // zero maximum turns the upper check off
    write_setting(REG_CPLX_THRESH, 16'd0);
    send_beat(8'h41, 8'h49, 1'b0);
    send_beat(8'h41, 8'h49, 1'b0);
    send_beat(8'h41, 8'h49, 1'b1);
  endtask

  // Random reads under each idling pattern, two settings per pattern.
  task automatic test_random_streams();
    int start_beats;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 50; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 50; end
        default: begin send_idle_pct = 32; pop_stall_pct = 32; end
      endcase
      for (int sub = 0; sub < 2; sub++) begin
        wait_idle();
        pick_settings();
        start_beats = beats_sent;
        while (beats_sent - start_beats < 40) send_random_read();
      end
    end
  endtask

  // Hold the receiver off while short reads keep coming, so the block fills
  // and pushes back on its input.
  task automatic test_full_backpressure();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    wait_idle();
    write_setting(REG_ENABLES, 16'd7);
    write_setting(REG_MIN_LEN, 16'd2);
    write_setting(REG_MAX_LEN, 16'd3);
    write_setting(REG_CPLX_THRESH, 16'd128);
    hold_len = 300;
    hold_seq++;
    for (int i = 0; i < 40; i++) send_read($urandom_range(3, 1), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n      = 1'b0;
    in_push    = 1'b0;
    in_base    = 8'h00;
    in_quality = 8'h00;
    in_last    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_ENABLES;
    cfg_data   = '0;
    reset_shadow();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_checks_directed();
    test_random_streams();
    test_full_backpressure();
    wait_idle();

    $display("Covered %0d base beats in %0d reads; %0d verdicts checked, %0d mismatches.",
             beats_sent, reads_sent, verdicts_checked, mismatches);
    $display("Input held off by a full block for %0d cycles.", full_cycles);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #(64'd30_000_000);
    $display("Timed out with %0d verdicts outstanding.", pending_verdicts.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
